// File: hdl/lidt_pkg.sv
// ----------------------------------------------------------------------------
// lidt_pkg
// Shared codes and types for the lock identifier set table.
// ----------------------------------------------------------------------------
package lidt_pkg;

    typedef enum logic [1:0] {
        OP_LOCK   = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } state_t;

    // command broadcast from the controller to every cell of the ring
    typedef struct packed {
        logic rotate;  // advance the ring by one entry
        logic drop;    // remove the head entry and close the gap
        logic load;    // write the new identifier just past the last entry
    } cell_cmd_t;

endpackage

// File: hdl/lidt_req_if.sv
// ----------------------------------------------------------------------------
// lidt_req_if
// Request channel: operation and holder identifier.
// ----------------------------------------------------------------------------
interface lidt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] holder_id;

    modport source (output valid, output operation, output holder_id, input ready);
    modport sink   (input valid, input operation, input holder_id, output ready);
endinterface

// File: hdl/lidt_rsp_if.sv
// ----------------------------------------------------------------------------
// lidt_rsp_if
// Result channel: status code and held flag.
// ----------------------------------------------------------------------------
interface lidt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       any_held;

    modport source (output valid, output status, output any_held, input ready);
    modport sink   (input valid, input status, input any_held, output ready);
endinterface

// File: hdl/lidt_cell.sv
// ----------------------------------------------------------------------------
// lidt_cell
// One slot of the identifier ring; takes its neighbor's entry on a rotate.
// ----------------------------------------------------------------------------
module lidt_cell
    import lidt_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int CNT_W   = 4,
    parameter int ID_BITS = 8
) (
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic [CNT_W-1:0]   count,
    input  logic [ID_BITS-1:0] head_id,
    input  logic [ID_BITS-1:0] right_id,
    input  logic [ID_BITS-1:0] load_id,
    output logic [ID_BITS-1:0] id
);

    localparam logic [CNT_W:0] IDX  = (CNT_W+1)'(INDEX);
    localparam logic [CNT_W:0] IDX1 = (CNT_W+1)'(INDEX + 1);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               below_last;
    logic               is_last;
    logic               is_free;

    assign below_last = IDX1 < {1'b0, count};
    assign is_last    = IDX1 == {1'b0, count};
    assign is_free    = IDX == {1'b0, count};

    always_comb
    begin
        id_next = id_reg;
        if (cmd.rotate)
        begin
            if (below_last)
                id_next = right_id;
            else if (is_last)
                id_next = head_id;
        end
        else if (cmd.drop)
        begin
            if (below_last)
                id_next = right_id;
        end
        else if (cmd.load)
        begin
            if (is_free)
                id_next = load_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

// File: hdl/lidt_ctrl.sv
// ----------------------------------------------------------------------------
// lidt_ctrl
// Sequencer: walks the ring at most once per request, decides, and holds the result.
// ----------------------------------------------------------------------------
module lidt_ctrl
    import lidt_pkg::*;
#(
    parameter int MAX_HOLDERS = 8,
    parameter int CNT_W       = 4,
    parameter int ID_BITS     = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    input  logic [ID_BITS-1:0] in_id,
    input  logic [ID_BITS-1:0] head_id,
    output cell_cmd_t          cmd,
    output logic [CNT_W-1:0]   count,
    output logic [ID_BITS-1:0] target_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic               out_any_held
);

    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_HOLDERS);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    state_t             state_reg, state_next;
    logic [1:0]         op_reg;
    logic [ID_BITS-1:0] tgt_reg;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic               any_reg, any_next;

    logic               accept;
    logic               out_free;
    logic               walked;
    logic               hit;
    logic               done;
    logic               resolve;
    status_t            res_status;
    logic               want_load;
    logic               want_drop;
    logic               want_rotate;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign walked   = step_reg == count_reg;
    assign hit      = !walked && (head_id == tgt_reg);

    // decision for the current walk step
    always_comb
    begin
        done        = 1'b0;
        res_status  = ST_OK;
        want_load   = 1'b0;
        want_drop   = 1'b0;
        want_rotate = 1'b0;
        case (op_reg)
            OP_LOCK:
            begin
                if (tgt_reg == '0 || hit)
                    done = 1'b1;
                else if (walked)
                begin
                    done = 1'b1;
                    if (count_reg < MAX_C)
                        want_load = 1'b1;
                    else
                        res_status = ST_FULL;
                end
                else
                    want_rotate = 1'b1;
            end
            OP_UNLOCK:
            begin
                if (tgt_reg == '0 || walked)
                begin
                    done       = 1'b1;
                    res_status = ST_NOT_FOUND;
                end
                else if (hit)
                begin
                    done      = 1'b1;
                    want_drop = 1'b1;
                end
                else
                    want_rotate = 1'b1;
            end
            default:
                done = 1'b1;
        endcase
    end

    assign resolve = (state_reg == S_WALK) && done && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_WALK;
            S_WALK:  if (resolve) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd.rotate     = (state_reg == S_WALK) && want_rotate;
        cmd.drop       = resolve && want_drop;
        cmd.load       = resolve && want_load;
        count_next     = count_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
            count_next = count_reg + ONE_C;
        else if (cmd.drop)
            count_next = count_reg - ONE_C;
        if (accept)
            step_next = '0;
        else if (cmd.rotate)
            step_next = step_reg + ONE_C;
        if (resolve)
        begin
            status_next    = res_status;
            any_next       = count_next != '0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        status_reg <= status_next;
        any_reg    <= any_next;
        if (accept)
        begin
            op_reg  <= in_op;
            tgt_reg <= in_id;
        end
    end

    assign in_ready     = state_reg == S_IDLE;
    assign count        = count_reg;
    assign target_id    = tgt_reg;
    assign out_valid    = out_valid_reg;
    assign out_status   = status_reg;
    assign out_any_held = any_reg;

endmodule

// File: hdl/lock_id_set_table.sv
// ----------------------------------------------------------------------------
// lock_id_set_table
// Set of nonzero holder identifiers kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
//
//   channel | dir | word fields            | handshake
//   --------+-----+------------------------+-------------
//   req     | in  | operation, holder_id   | valid/ready
//   rsp     | out | status, any_held       | valid/ready
//
// Flow: one request at a time. A query, or a lock/unlock of identifier
// zero, resolves without a ring walk; a lock or unlock resolves after at
// most one full ring walk, which shows one entry per cycle at cell 0.
// Reset: rst_n clears the sequencer, the entry count and the result valid;
// cells hold no reset and are only read below the entry count.
// Stalls: a finished result sits in the output register while the next
// request is taken; a walk that finishes while that register is still full
// holds its decision until the register drains.
//
// Entries live compactly in cells 0 .. count-1 in no fixed order. A rotate
// moves every live entry one cell down and wraps cell 0 to the last live
// cell, so the head cell visits each entry once per walk. An unlock drops
// the head on a match; a lock appends at cell count after a full walk.
// ----------------------------------------------------------------------------
module lock_id_set_table
    import lidt_pkg::*;
#(
    parameter int MAX_HOLDERS = 8,
    parameter int ID_BITS     = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    lidt_req_if.sink   req,
    lidt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(MAX_HOLDERS + 1);

    logic [ID_BITS-1:0] cell_id [MAX_HOLDERS];
    logic [ID_BITS-1:0] in_id;
    logic [ID_BITS-1:0] target_id;
    logic [CNT_W-1:0]   count;
    cell_cmd_t          cmd;
    logic [39:0]        holder_ext;

    // take the identifier in its low ID_BITS bits
    assign holder_ext = {32'd0, req.holder_id};
    assign in_id      = holder_ext[ID_BITS-1:0];

    lidt_ctrl #(
        .MAX_HOLDERS (MAX_HOLDERS),
        .CNT_W       (CNT_W),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .in_op        (req.operation),
        .in_id        (in_id),
        .head_id      (cell_id[0]),
        .cmd          (cmd),
        .count        (count),
        .target_id    (target_id),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_any_held (rsp.any_held)
    );

    // ring of cells; the last cell never takes from its right neighbor
    for (genvar i = 0; i < MAX_HOLDERS; i++)
    begin : g_cell
        lidt_cell #(
            .INDEX   (i),
            .CNT_W   (CNT_W),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .count    (count),
            .head_id  (cell_id[0]),
            .right_id (cell_id[(i + 1) % MAX_HOLDERS]),
            .load_id  (target_id),
            .id       (cell_id[i])
        );
    end

endmodule
